// ----- hdl/lla_pkg.sv -----
// Shared types and constants for the Life-like automaton stencil.
// No dependencies; all other files in hdl/ except lla_line_store refer to this package by scoped names.
package lla_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BIRTH_MASK   = 2'd2,
    REG_SURVIVE_MASK = 2'd3
  } cfg_reg_t;

  localparam int CFG_DATA_W = 11;
  localparam int SIZE_W     = 11;
  localparam int MASK_W     = 9;
  localparam int COUNT_W    = 4;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [MASK_W-1:0] BIRTH_MASK_RST   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_MASK_RST = 9'd12;

  // Per-cell flags from the position tracker to the pipeline
  typedef struct packed {
    logic emit;  // interior cell: a result goes out
    logic last;  // last interior cell of the frame
  } stage_flags_t;

endpackage

// ----- hdl/lla_ifs.sv -----
// Valid/ready channel interfaces: cell input, result output, register write.
// Depends on lla_pkg for field widths.
interface lla_in_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic frame_start;
  modport source (output valid, output cell_alive, output frame_start, input ready);
  modport sink (input valid, input cell_alive, input frame_start, output ready);
endinterface

interface lla_out_if;
  logic valid;
  logic ready;
  logic next_state;
  logic last_of_frame;
  modport source (output valid, output next_state, output last_of_frame, input ready);
  modport sink (input valid, input next_state, input last_of_frame, output ready);
endinterface

interface lla_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     index;
  logic [lla_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/lla_position.sv -----
// Row/column tracker: clamps the frame size, flags interior and last cells.
// Depends on lla_pkg (stage_flags_t, SIZE_W).
module lla_position #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        frame_start,
  input  logic [lla_pkg::SIZE_W-1:0]  frame_width,
  input  logic [lla_pkg::SIZE_W-1:0]  frame_height,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output lla_pkg::stage_flags_t       flags
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int ZW0 = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                       $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int ZW  = (ZW0 > lla_pkg::SIZE_W) ? ZW0 : lla_pkg::SIZE_W;

  logic [AW-1:0] column_count_r, column_count_nxt;
  logic [RW-1:0] row_count_r, row_count_nxt;
  logic [ZW-1:0] fw_z, fh_z;
  logic [AW-1:0] col_last;
  logic [RW-1:0] row_last, row;
  logic          row_end, frame_end;

  assign fw_z = ZW'(frame_width);
  assign fh_z = ZW'(frame_height);

  // Clamp sizes to 3..MAX and take the last index
  always_comb begin
    if (fw_z < ZW'(3))                col_last = AW'(2);
    else if (fw_z > ZW'(MAX_WIDTH))   col_last = AW'(MAX_WIDTH - 1);
    else                              col_last = AW'(fw_z - ZW'(1));
    if (fh_z < ZW'(3))                row_last = RW'(2);
    else if (fh_z > ZW'(MAX_HEIGHT))  row_last = RW'(MAX_HEIGHT - 1);
    else                              row_last = RW'(fh_z - ZW'(1));
  end

  assign col       = frame_start ? '0 : column_count_r;
  assign row       = frame_start ? '0 : row_count_r;
  assign row_end   = col >= col_last;
  assign frame_end = row >= row_last;

  assign flags.emit = (row >= RW'(2)) && (col >= AW'(2));
  assign flags.last = row_end && frame_end;

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (advance) begin
      if (row_end) begin
        column_count_nxt = '0;
        row_count_nxt    = frame_end ? '0 : row + RW'(1);
      end else begin
        column_count_nxt = col + AW'(1);
        row_count_nxt    = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // Column steps by one inside a row
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !row_end |=> column_count_r == $past(col) + AW'(1))
    else $error("column counter did not step");

endmodule

// ----- hdl/lla_line_store.sv -----
// Two line stores (rows r-2 and r-1) kept as one 2-bit wide memory, with
// registered read and a write-to-read bypass. Standalone, no package use.
module lla_line_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic                         wr_upper,
  input  logic                         wr_middle,
  output logic                         rd_upper,
  output logic                         rd_middle
);

  logic [1:0] line_mem [MAX_WIDTH];
  logic [1:0] mem_rd_r;
  logic [1:0] byp_data_r;
  logic       byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= {wr_upper, wr_middle};
    end
    if (rd_en) begin
      mem_rd_r   <= line_mem[rd_addr];
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= {wr_upper, wr_middle};
    end
  end

  // Take the just-written entry over the stale read
  assign {rd_upper, rd_middle} = byp_r ? byp_data_r : mem_rd_r;

endmodule

// ----- hdl/lla_rule.sv -----
// 3x3 window, neighbour count and birth/survive rule lookup.
// Depends on lla_pkg (MASK_W, COUNT_W).
module lla_rule (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        top,
  input  logic                        mid,
  input  logic                        cur,
  input  logic [lla_pkg::MASK_W-1:0]  birth_mask,
  input  logic [lla_pkg::MASK_W-1:0]  survive_mask,
  output logic                        next_state
);

  // bits 0..2: column c-2, bits 3..5: column c-1 (top, mid, bottom)
  logic [5:0]                    window_r;
  logic [lla_pkg::COUNT_W-1:0]   count;
  logic [lla_pkg::MASK_W-1:0]    mask;

  assign count = lla_pkg::COUNT_W'(window_r[0]) + lla_pkg::COUNT_W'(window_r[1]) +
                 lla_pkg::COUNT_W'(window_r[2]) + lla_pkg::COUNT_W'(window_r[3]) +
                 lla_pkg::COUNT_W'(window_r[5]) + lla_pkg::COUNT_W'(top) +
                 lla_pkg::COUNT_W'(mid) + lla_pkg::COUNT_W'(cur);

  assign mask       = window_r[4] ? survive_mask : birth_mask;
  assign next_state = mask[count];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (advance) begin
      window_r <= {cur, mid, top, window_r[5:3]};
    end
  end

endmodule

// ----- hdl/life_like_automaton_stencil.sv -----
// Top level of the Life-like automaton stencil: config registers, pipeline
// control and output register. Depends on lla_pkg, lla_ifs, lla_position,
// lla_line_store and lla_rule.
//
//  channel    dir  fields                          handshake
//  in_chan    in   cell_alive, frame_start         valid/ready
//  out_chan   out  next_state, last_of_frame       valid/ready
//  cfg_chan   in   index (2b), data (11b)          valid/ready, ready always 1
//
// One cell per clock, sustained unless a stalled out_chan holds a result. A
// cell passes the line store read (registered) on transfer, then rule and
// window update into the output register. The line store has one write and
// one read port; a bypass covers a read of the column written in the same cycle.
// Reset (rst_n low, synchronous) clears counters, window and valids and
// loads the default frame 640x480 with birth {3}, survive {2,3}; the line
// stores are not cleared. A stalled output holds only cells that produce a
// result; border cells drain without waiting on out_chan.ready.
module life_like_automaton_stencil #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  lla_in_if.sink       in_chan,
  lla_out_if.source    out_chan,
  lla_cfg_if.sink      cfg_chan
);

  localparam int AW = $clog2(MAX_WIDTH);

  // Configuration registers
  logic [lla_pkg::SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [lla_pkg::MASK_W-1:0] birth_mask_r, survive_mask_r;

  // Stage 1: registered cell, its column and flags
  logic                  s1_valid_r;
  logic                  s1_cur_r;
  logic [AW-1:0]         s1_col_r;
  lla_pkg::stage_flags_t s1_flags_r;

  // Output register
  logic out_valid_r, next_state_r, last_of_frame_r;

  logic                  in_accept, s1_advance, out_load;
  logic [AW-1:0]         in_col;
  lla_pkg::stage_flags_t in_flags;
  logic                  top, mid, rule_state;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lla_pkg::FRAME_WIDTH_RST;
      frame_height_r <= lla_pkg::FRAME_HEIGHT_RST;
      birth_mask_r   <= lla_pkg::BIRTH_MASK_RST;
      survive_mask_r <= lla_pkg::SURVIVE_MASK_RST;
    end else if (cfg_chan.valid) begin
      unique case (lla_pkg::cfg_reg_t'(cfg_chan.index))
        lla_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_chan.data;
        lla_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_chan.data;
        lla_pkg::REG_BIRTH_MASK:   birth_mask_r   <= cfg_chan.data[lla_pkg::MASK_W-1:0];
        lla_pkg::REG_SURVIVE_MASK: survive_mask_r <= cfg_chan.data[lla_pkg::MASK_W-1:0];
      endcase
    end
  end

  // Advance stage 1 when its cell needs no output slot or a slot is free
  assign s1_advance = s1_valid_r &&
                      (!s1_flags_r.emit || !out_valid_r || out_chan.ready);
  assign out_load   = s1_advance && s1_flags_r.emit;
  assign in_chan.ready = !s1_valid_r || s1_advance;
  assign in_accept     = in_chan.valid && in_chan.ready;

  lla_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_accept),
    .frame_start  (in_chan.frame_start),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .col          (in_col),
    .flags        (in_flags)
  );

  // Read rows r-2 and r-1 on transfer; write back when the cell leaves stage 1
  lla_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (in_accept),
    .rd_addr   (in_col),
    .wr_en     (s1_advance),
    .wr_addr   (s1_col_r),
    .wr_upper  (mid),
    .wr_middle (s1_cur_r),
    .rd_upper  (top),
    .rd_middle (mid)
  );

  lla_rule u_rule (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (s1_advance),
    .top          (top),
    .mid          (mid),
    .cur          (s1_cur_r),
    .birth_mask   (birth_mask_r),
    .survive_mask (survive_mask_r),
    .next_state   (rule_state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cur_r   <= in_chan.cell_alive;
      s1_col_r   <= in_col;
      s1_flags_r <= in_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      next_state_r    <= rule_state;
      last_of_frame_r <= s1_flags_r.last;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.next_state    = next_state_r;
  assign out_chan.last_of_frame = last_of_frame_r;

  // No transfer while stage 1 is held
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_advance |-> !in_accept)
    else $error("input transfer while stage 1 is held");

  // Last-of-frame only on an interior cell
  a_last_interior: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_flags_r.last |-> s1_flags_r.emit)
    else $error("last flag on a border cell");

  // Output register loads only into a free or draining slot
  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_chan.ready)
    else $error("output register overwritten");

endmodule
